// ===== hdl/mwam_pkg.sv =====
// package for the mix word add / multiply / divide unit
// word widths, operation codes and the pipeline word type; no dependencies
`timescale 1ns / 1ps
package mwam_pkg;
	localparam int MAG_BITS            = 30;
	localparam int WORD_BITS           = MAG_BITS + 1;
	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES          = MAG_BITS / DIV_STEPS_PER_STAGE;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_MUL = 2'd1,
		KIND_DIV = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [MAG_BITS-1:0]  mag_t;

	// one word in flight: finished words for add/mul, divider state otherwise
	typedef struct packed {
		logic  is_div;
		logic  ovf;
		word_t wa;
		word_t wx;
		mag_t  md;
		mag_t  r;
		mag_t  q;
		logic  sq;
		logic  sr;
	} pipe_t;
endpackage

// ===== hdl/mwam_if.sv =====
// valid/ready channels of the mix arithmetic unit
// depends on mwam_pkg
`timescale 1ns / 1ps
interface mwam_req_if;
	logic             valid;
	logic             ready;
	mwam_pkg::kind_t  kind;
	mwam_pkg::word_t  operand_a;
	mwam_pkg::word_t  operand_x;
	mwam_pkg::word_t  operand_v;
	modport source(output valid, kind, operand_a, operand_x, operand_v, input ready);
	modport sink(input valid, kind, operand_a, operand_x, operand_v, output ready);
endinterface

interface mwam_rsp_if;
	logic            valid;
	logic            ready;
	mwam_pkg::word_t word_a;
	mwam_pkg::word_t word_x;
	logic            overflow;
	modport source(output valid, word_a, word_x, overflow, input ready);
	modport sink(input valid, word_a, word_x, overflow, output ready);
endinterface

// ===== hdl/mwam_front.sv =====
// first pipeline stage: operand decode, add, multiply, divide range check
// depends on mwam_pkg
`timescale 1ns / 1ps
module mwam_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  mwam_pkg::kind_t  kind,
	input  mwam_pkg::word_t  operand_a,
	input  mwam_pkg::word_t  operand_x,
	input  mwam_pkg::word_t  operand_v,
	output logic             v_s1,
	output mwam_pkg::pipe_t  p_s1
);
	import mwam_pkg::*;

	logic                  sa, sv;
	mag_t                  ma, mv, mx;
	logic [MAG_BITS:0]     sum;
	logic [2*MAG_BITS-1:0] prod;
	pipe_t                 nxt;

	always_comb begin
		sa   = operand_a[MAG_BITS];
		sv   = operand_v[MAG_BITS];
		ma   = operand_a[MAG_BITS-1:0];
		mv   = operand_v[MAG_BITS-1:0];
		mx   = operand_x[MAG_BITS-1:0];
		sum  = {1'b0, ma} + {1'b0, mv};
		prod = ma * mv;
		nxt  = '0;
		case (kind)
			KIND_ADD: begin
				if (sa == sv) begin
					if (sum[MAG_BITS]) begin
						nxt.wa  = {sa, sum[MAG_BITS-1:0]};
						nxt.wx  = {sa, mag_t'(1)};
						nxt.ovf = 1'b1;
					end else if (sum != '0) begin
						nxt.wa = {sa, sum[MAG_BITS-1:0]};
					end
				end else if (ma < mv) begin
					nxt.wa = {sv, mag_t'(mv - ma)};
				end else begin
					nxt.wa = {sa, mag_t'(ma - mv)};
				end
			end
			KIND_MUL: begin
				nxt.wa = {sa ^ sv, prod[2*MAG_BITS-1:MAG_BITS]};
				nxt.wx = {sa ^ sv, prod[MAG_BITS-1:0]};
			end
			KIND_DIV: begin
				if (mv == '0 || mv <= ma) begin
					nxt.ovf = 1'b1;
				end else begin
					nxt.is_div = 1'b1;
					nxt.md     = mv;
					nxt.r      = ma;
					nxt.q      = mx;
					nxt.sq     = sa ^ sv;
					nxt.sr     = sa;
				end
			end
			default: nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_v) begin
			p_s1 <= nxt;
		end
	end
endmodule

// ===== hdl/mwam_div_stage.sv =====
// one divider pipeline stage: DIV_STEPS_PER_STAGE restoring shift-subtract steps
// depends on mwam_pkg
`timescale 1ns / 1ps
module mwam_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  mwam_pkg::pipe_t in_p,
	output logic            v_q,
	output mwam_pkg::pipe_t p_q
);
	import mwam_pkg::*;

	pipe_t             nxt;
	logic [MAG_BITS:0] r2;

	always_comb begin
		nxt = in_p;
		r2  = '0;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			r2    = {nxt.r, nxt.q[MAG_BITS-1]};
			nxt.q = {nxt.q[MAG_BITS-2:0], 1'b0};
			if ({1'b0, nxt.md} <= r2) begin
				r2       = r2 - {1'b0, nxt.md};
				nxt.q[0] = 1'b1;
			end
			nxt.r = r2[MAG_BITS-1:0];
		end
		if (!in_p.is_div) begin
			nxt = in_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_v) begin
			p_q <= nxt;
		end
	end
endmodule

// ===== hdl/mix_word_add_mul_div_unit.sv =====
// top level of the mix sign-magnitude add / multiply / divide unit
// depends on mwam_pkg, mwam_if, mwam_front, mwam_div_stage
//
// usage:
//  - req channel takes one word per handshake (valid && ready): kind, operand_a,
//    operand_x, operand_v; rsp channel returns one word per request in order:
//    word_a, word_x, overflow
//  - every request gives exactly one response; kind 3 gives all zeros
//  - pipeline: one front stage (add, 30x30 multiply, divide range check), then
//    15 divider stages of two restoring steps each, then the output register
//  - throughput is one word per cycle unless the receiver stalls rsp;
//    the depth is set by the 30 divide steps
//  - each stage holds a valid bit; a stage loads when it is empty or its
//    contents move on, so bubbles close up and a stalled receiver only backs
//    up the pipe once all 17 stages are full
//  - a stalled response holds its word; nothing is dropped or repeated
//  - reset clears all valid bits at once; the block accepts right after reset
`timescale 1ns / 1ps
module mix_word_add_mul_div_unit (
	input logic       clk,
	input logic       arst_n,
	mwam_req_if.sink  req,
	mwam_rsp_if.source rsp
);
	import mwam_pkg::*;

	// stage 0 is the front register, stages 1..DIV_STAGES the divider
	logic  v_s [DIV_STAGES+1];
	pipe_t p_s [DIV_STAGES+1];
	logic  en  [DIV_STAGES+1];
	logic  out_en;

	logic  out_v_q;
	word_t out_a_q;
	word_t out_x_q;
	logic  out_ovf_q;

	// output register loads when empty or being taken
	assign out_en = !out_v_q || rsp.ready;

	// a stage may load when it is empty or its word moves to the next one
	always_comb begin
		en[DIV_STAGES] = !v_s[DIV_STAGES] || out_en;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign req.ready = en[0];

	mwam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en[0]),
		.in_v      (req.valid),
		.kind      (req.kind),
		.operand_a (req.operand_a),
		.operand_x (req.operand_x),
		.operand_v (req.operand_v),
		.v_s1      (v_s[0]),
		.p_s1      (p_s[0])
	);

	for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
		mwam_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en[g]),
			.in_v   (v_s[g-1]),
			.in_p   (p_s[g-1]),
			.v_q    (v_s[g]),
			.p_q    (p_s[g])
		);
	end

	// output register: pick divider result or finished add/mul word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= v_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && v_s[DIV_STAGES]) begin
			out_ovf_q <= p_s[DIV_STAGES].ovf;
			if (p_s[DIV_STAGES].is_div) begin
				out_a_q <= {p_s[DIV_STAGES].sq, p_s[DIV_STAGES].q};
				out_x_q <= {p_s[DIV_STAGES].sr, p_s[DIV_STAGES].r};
			end else begin
				out_a_q <= p_s[DIV_STAGES].wa;
				out_x_q <= p_s[DIV_STAGES].wx;
			end
		end
	end

	assign rsp.valid    = out_v_q;
	assign rsp.word_a   = out_a_q;
	assign rsp.word_x   = out_x_q;
	assign rsp.overflow = out_ovf_q;
endmodule

// ===== hdl/mwam_checker.sv =====
// port-level checks for the mix arithmetic unit, bound to the top level
// depends on mwam_pkg
`timescale 1ns / 1ps
module mwam_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input mwam_pkg::word_t word_a,
	input mwam_pkg::word_t word_x,
	input logic            overflow
);
	import mwam_pkg::*;

	// stalled response keeps its word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(word_a) && $stable(word_x)
		&& $stable(overflow))
		else $error("response changed while stalled");

	// an empty output stage means the whole pipe can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with empty output");

	// add carry word is always plus or minus one
	a_carry_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow && word_x != '0 |-> word_x[MAG_BITS-1:0] == mag_t'(1))
		else $error("bad carry word");

	// divide overflow gives zero quotient
	a_div_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow && word_x == '0 |-> word_a == '0)
		else $error("divide overflow with nonzero quotient");
endmodule

bind mix_word_add_mul_div_unit mwam_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.word_a    (rsp.word_a),
	.word_x    (rsp.word_x),
	.overflow  (rsp.overflow)
);
